>>> sv/dcp_pkg.sv
// Shared constants and codes of the decimal coordinate pair parser.
`timescale 1ns / 1ps
`default_nettype none
package dcp_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Action codes of an input item.
  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // Configuration register indexes.
  localparam logic REG_POINT_SEP = 1'b0;
  localparam logic REG_FIELD_SEP = 1'b1;

  localparam logic [7:0] POINT_SEP_RESET = 8'd46;
  localparam logic [7:0] FIELD_SEP_RESET = 8'd44;

  localparam int PADDR_BITS = 3;

  // Field scanner states.
  localparam logic [1:0] SCAN_SKIP   = 2'd0;
  localparam logic [1:0] SCAN_SIGN   = 2'd1;
  localparam logic [1:0] SCAN_DIGITS = 2'd2;
  localparam logic [1:0] SCAN_STOP   = 2'd3;

  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;

endpackage
`default_nettype wire

>>> sv/dcp_if.sv
// Stream interfaces for text bytes in and coordinate pairs out.
`timescale 1ns / 1ps
`default_nettype none
interface dcp_text_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_in;

  modport source (output valid, action, char_in, input ready);
  modport sink   (input valid, action, char_in, output ready);
endinterface

interface dcp_pair_if import dcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         pair_valid;
  logic                         done_res;

  modport source (output valid, x_coord, y_coord, pair_valid, done_res, input ready);
  modport sink   (input valid, x_coord, y_coord, pair_valid, done_res, output ready);
endinterface
`default_nettype wire

>>> sv/decimal_coordinate_pair_parser_top.sv
// Top level of the decimal coordinate pair parser.
`timescale 1ns / 1ps
`default_nettype none
// Takes ASCII text one byte per transfer, plus start and end actions, and
// returns signed coordinate pairs. Each byte is handled in the cycle it is
// accepted: the token state is updated and any finished pair is loaded into
// the output register, so one byte is taken every cycle while the output
// register is empty or being drained. A pair is offered in the cycle after
// the byte that ends it. Fields follow atoi rules and saturate to COORD_BITS.
// The two separator bytes are set through the APB port at offsets 0 and 4.
module decimal_coordinate_pair_parser_top import dcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  dcp_text_if.sink              text,
  dcp_pair_if.source            pair,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [PADDR_BITS-1:0] paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int MW = COORD_BITS + 4;
  localparam logic [MW-1:0] MAG_LIMIT = MW'(1) << (COORD_BITS - 1);

  logic [7:0] point_sep;
  logic [7:0] field_sep;

  logic                  in_second_field, in_second_field_next;
  logic [1:0]            scan_stage, scan_stage_next;
  logic                  is_negative, is_negative_next;
  logic [COORD_BITS-1:0] first_value, first_value_next;
  logic [COORD_BITS-1:0] magnitude_acc, magnitude_acc_next;

  logic                  out_valid;
  logic [COORD_BITS-1:0] x_reg, y_reg;
  logic                  pv_reg, done_reg;

  logic                  accept, emit;
  logic [COORD_BITS-1:0] emit_x, emit_y;
  logic                  emit_pv, emit_done;
  logic [COORD_BITS-1:0] field_value;
  logic [MW-1:0]         mag_step;
  logic                  is_digit, is_space;
  logic [7:0]            c;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_sep <= POINT_SEP_RESET;
      field_sep <= FIELD_SEP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_POINT_SEP: point_sep <= pwdata[7:0];
        REG_FIELD_SEP: field_sep <= pwdata[7:0];
        default:       point_sep <= point_sep;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POINT_SEP: prdata = {24'd0, point_sep};
      REG_FIELD_SEP: prdata = {24'd0, field_sep};
      default:       prdata = 32'd0;
    endcase
  end

  // Handshake: a byte is taken whenever the output register can take a result.
  assign text.ready = !out_valid || pair.ready;
  assign accept     = text.valid && text.ready;
  assign c          = text.char_in;

  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));

  // Digits 0 to 9 sit in the low nibble of their ASCII codes.
  assign mag_step = (MW'(magnitude_acc) << 3) + (MW'(magnitude_acc) << 1)
                  + MW'(c[3:0]);

  // A saturated magnitude equals the limit, so its top bit alone flags it.
  always_comb begin
    if (is_negative) begin
      field_value = ~magnitude_acc + COORD_BITS'(1);
    end else if (magnitude_acc[COORD_BITS-1]) begin
      field_value = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      field_value = magnitude_acc;
    end
  end

  always_comb begin
    in_second_field_next = in_second_field;
    scan_stage_next      = scan_stage;
    is_negative_next     = is_negative;
    first_value_next     = first_value;
    magnitude_acc_next   = magnitude_acc;
    emit      = 1'b0;
    emit_x    = '0;
    emit_y    = '0;
    emit_pv   = 1'b0;
    emit_done = 1'b0;
    if (accept) begin
      unique case (text.action)
        ACT_START: begin
          in_second_field_next = 1'b0;
          first_value_next     = '0;
          scan_stage_next      = SCAN_SKIP;
          is_negative_next     = 1'b0;
          magnitude_acc_next   = '0;
        end
        ACT_END: begin
          emit      = 1'b1;
          emit_done = 1'b1;
          emit_pv   = in_second_field;
          if (in_second_field) begin
            emit_x = first_value;
            emit_y = field_value;
          end
          in_second_field_next = 1'b0;
          first_value_next     = '0;
          scan_stage_next      = SCAN_SKIP;
          is_negative_next     = 1'b0;
          magnitude_acc_next   = '0;
        end
        ACT_DATA: begin
          if (c == point_sep) begin
            if (in_second_field) begin
              emit    = 1'b1;
              emit_pv = 1'b1;
              emit_x  = first_value;
              emit_y  = field_value;
            end
            in_second_field_next = 1'b0;
            first_value_next     = '0;
            scan_stage_next      = SCAN_SKIP;
            is_negative_next     = 1'b0;
            magnitude_acc_next   = '0;
          end else if (c == field_sep && !in_second_field) begin
            first_value_next     = field_value;
            in_second_field_next = 1'b1;
            scan_stage_next      = SCAN_SKIP;
            is_negative_next     = 1'b0;
            magnitude_acc_next   = '0;
          end else if (scan_stage == SCAN_SKIP && is_space) begin
            scan_stage_next = SCAN_SKIP;
          end else if (scan_stage == SCAN_SKIP
                       && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            is_negative_next = (c == CHAR_MINUS);
            scan_stage_next  = SCAN_SIGN;
          end else if (scan_stage != SCAN_STOP) begin
            if (is_digit) begin
              magnitude_acc_next = (mag_step > MAG_LIMIT)
                                 ? MAG_LIMIT[COORD_BITS-1:0]
                                 : mag_step[COORD_BITS-1:0];
              scan_stage_next    = SCAN_DIGITS;
            end else begin
              scan_stage_next = SCAN_STOP;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_second_field <= 1'b0;
      scan_stage      <= SCAN_SKIP;
      is_negative     <= 1'b0;
      first_value     <= '0;
      magnitude_acc   <= '0;
      out_valid       <= 1'b0;
    end else begin
      in_second_field <= in_second_field_next;
      scan_stage      <= scan_stage_next;
      is_negative     <= is_negative_next;
      first_value     <= first_value_next;
      magnitude_acc   <= magnitude_acc_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pair.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      x_reg    <= emit_x;
      y_reg    <= emit_y;
      pv_reg   <= emit_pv;
      done_reg <= emit_done;
    end
  end

  assign pair.valid      = out_valid;
  assign pair.x_coord    = x_reg;
  assign pair.y_coord    = y_reg;
  assign pair.pair_valid = pv_reg;
  assign pair.done_res   = done_reg;

endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the decimal coordinate pair parser top level.
`timescale 1ns / 1ps

package dcp_check_pkg;
  import dcp_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam logic [CB:0] MAG_CAP = {2'b01, {(CB - 1){1'b0}}};
  localparam logic [CB-1:0] POS_MAX = {1'b0, {(CB - 1){1'b1}}};
  // The fourth action code carries no meaning and must be ignored.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [CB-1:0] x_coord;
    logic signed [CB-1:0] y_coord;
    logic                 pair_valid;
    logic                 done_res;
  } pair_t;

  class pair_scoreboard;
    logic [7:0]    point_sep;
    logic [7:0]    field_sep;
    bit            in_y;
    logic [1:0]    stage;
    bit            neg;
    logic [CB-1:0] x_held;
    logic [CB:0]   mag;
    pair_t         pending[$];
    int            errors;
    int            pairs_seen;
    int            dones_seen;

    function new();
      point_sep  = POINT_SEP_RESET;
      field_sep  = FIELD_SEP_RESET;
      errors     = 0;
      pairs_seen = 0;
      dones_seen = 0;
      clear_token();
    endfunction

    function void set_separator(logic idx, logic [7:0] value);
      if (idx == REG_POINT_SEP) begin
        point_sep = value;
      end else begin
        field_sep = value;
      end
    endfunction

    function void clear_field();
      stage = SCAN_SKIP;
      neg   = 1'b0;
      mag   = '0;
    endfunction

    function void clear_token();
      in_y   = 1'b0;
      x_held = '0;
      clear_field();
    endfunction

    // Saturated two's complement value of the field being read.
    function logic [CB-1:0] field_value();
      logic [CB:0] negated;
      negated = '0 - mag;
      if (neg) return negated[CB-1:0];
      if (mag > {1'b0, POS_MAX}) return POS_MAX;
      return mag[CB-1:0];
    endfunction

    function void scan_char(logic [7:0] c);
      bit          digit;
      bit          space;
      int unsigned nxt;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      if (stage == SCAN_STOP) return;
      if (stage == SCAN_SKIP) begin
        if (space) return;
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          neg   = (c == CHAR_MINUS);
          stage = SCAN_SIGN;
          return;
        end
      end
      if (digit) begin
        nxt   = mag * 10 + (c - CHAR_ZERO);
        mag   = (nxt > MAG_CAP) ? MAG_CAP : nxt[CB:0];
        stage = SCAN_DIGITS;
      end else begin
        stage = SCAN_STOP;
      end
    endfunction

    // Called for every accepted text transfer; queues the pair or end result it completes.
    function void note_transfer(logic [1:0] act, logic [7:0] c);
      pair_t want;
      case (act)
        ACT_START: begin
          clear_token();
        end
        ACT_END: begin
          want.x_coord    = in_y ? x_held : '0;
          want.y_coord    = in_y ? field_value() : '0;
          want.pair_valid = in_y;
          want.done_res   = 1'b1;
          pending = {pending, want};
          clear_token();
        end
        ACT_DATA: begin
          if (c == point_sep) begin
            if (in_y) begin
              want.x_coord    = x_held;
              want.y_coord    = field_value();
              want.pair_valid = 1'b1;
              want.done_res   = 1'b0;
              pending = {pending, want};
            end
            clear_token();
          end else if (c == field_sep && !in_y) begin
            x_held = field_value();
            in_y   = 1'b1;
            clear_field();
          end else begin
            scan_char(c);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_pair(pair_t got);
      pair_t want;
      if (pending.size() == 0) begin
        $error("pair transfer with nothing expected: x_coord %0d y_coord %0d done_res %0b",
               got.x_coord, got.y_coord, got.done_res);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.x_coord !== want.x_coord) begin
        $error("x_coord: expected %0d, got %0d", want.x_coord, got.x_coord);
        errors++;
      end
      if (got.y_coord !== want.y_coord) begin
        $error("y_coord: expected %0d, got %0d", want.y_coord, got.y_coord);
        errors++;
      end
      if (got.pair_valid !== want.pair_valid) begin
        $error("pair_valid: expected %0b, got %0b", want.pair_valid, got.pair_valid);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        errors++;
      end
      if (want.pair_valid) pairs_seen++;
      if (want.done_res) dones_seen++;
    endfunction
  endclass
endpackage

module tb;
  import dcp_pkg::*;
  import dcp_check_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  dcp_text_if text_ch ();
  dcp_pair_if #(.COORD_BITS(COORD_BITS_DEF)) pair_ch ();

  pair_scoreboard board = new();
  bit             calm = 1'b0;
  int             items_sent = 0;
  int             settings_used = 1;

  decimal_coordinate_pair_parser_top #(.COORD_BITS(COORD_BITS_DEF)) u_top (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .pair    (pair_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
    int gap;
    if (!calm && $urandom_range(0, 99) < 7) begin
      gap = $urandom_range(1, 4);
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid   <= 1'b1;
    text_ch.action  <= act;
    text_ch.char_in <= ch;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    board.note_transfer(act, ch);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_DATA, s[i]);
  endtask

  // One field: optional whitespace, optional sign, digits, maybe a stray byte.
  task automatic send_field();
    int    n;
    string num;
    num = "";
    repeat ($urandom_range(0, 2)) begin
      n = $urandom_range(9, 14);
      send_item(ACT_DATA, (n == 14) ? CHAR_SPACE : 8'(n));
    end
    case ($urandom_range(0, 3))
      0: send_item(ACT_DATA, CHAR_MINUS);
      1: send_item(ACT_DATA, CHAR_PLUS);
      default: begin
      end
    endcase
    case ($urandom_range(0, 9))
      0: num = "";
      1: num = $sformatf("%0d", $urandom_range(32766, 32769));
      2: num = $sformatf("%0d", $urandom);
      default: num = $sformatf("%0d", $urandom_range(0, 40000) >> $urandom_range(0, 12));
    endcase
    send_text(num);
    if ($urandom_range(0, 7) == 0) send_item(ACT_DATA, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_token();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      send_field();
      send_item(ACT_DATA, board.field_sep);
      send_field();
      send_item(ACT_DATA, board.point_sep);
    end else if (kind < 80) begin
      send_field();
      send_item(ACT_DATA, board.point_sep);
    end else if (kind < 86) begin
      send_field();
      send_item(ACT_DATA, board.field_sep);
      send_field();
      send_item(ACT_DATA, board.field_sep);
      send_field();
      send_item(ACT_DATA, board.point_sep);
    end else if (kind < 89) begin
      send_item(ACT_START, 8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      send_item(ACT_END, 8'($urandom_range(0, 255)));
    end else if (kind < 95) begin
      send_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_item(ACT_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) send_token();
  endtask

  // Hold the sender until every pair is out, then let the pipeline settle.
  task automatic wait_drain();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_BITS'({idx, 2'b00});
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Read the register straight back.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== value) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, prdata[7:0]);
      board.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    board.set_separator(idx, value);
  endtask

  task automatic set_separators(input logic [7:0] point, input logic [7:0] field);
    wait_drain();
    write_register(REG_POINT_SEP, point);
    write_register(REG_FIELD_SEP, field);
    settings_used++;
  endtask

  initial begin
    pair_t got;
    pair_ch.ready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if (pair_ch.valid && pair_ch.ready) begin
        got.x_coord    = pair_ch.x_coord;
        got.y_coord    = pair_ch.y_coord;
        got.pair_valid = pair_ch.pair_valid;
        got.done_res   = pair_ch.done_res;
        board.check_pair(got);
      end
      pair_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    text_ch.valid   = 1'b0;
    text_ch.action  = ACT_DATA;
    text_ch.char_in = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed text at the reset separators.
    send_item(ACT_START, 8'h00);
    send_text("+99999,-7a.");   // saturation, signs, stop at a non-digit
    send_text(", 4,5.");        // empty x; a second comma stops y
    send_text("3.");            // token without a comma is dropped
    send_item(ACT_UNUSED, 8'hFF);
    send_text("\t-9,");
    send_item(ACT_END, 8'h00);  // flushes the pending pair
    send_item(ACT_END, 8'hA5);  // nothing pending
    send_text("1,");
    send_item(ACT_START, 8'h5A); // clears the half-read token

    run_random(180);
    set_separators(8'h00, 8'hFF);
    run_random(220);
    set_separators(8'hFF, 8'h00);
    run_random(220);
    set_separators(8'd59, 8'd59);
    run_random(200);
    set_separators(8'd59, 8'd58);
    run_random(220);
    set_separators(8'($urandom), 8'($urandom));
    run_random(220);
    set_separators(POINT_SEP_RESET, FIELD_SEP_RESET);
    calm = 1'b1;
    run_random(200);
    calm = 1'b0;
    run_random(100);

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d text transfers under %0d separator settings.", items_sent,
             settings_used);
    $display("Checked %0d coordinate pairs and %0d end results.", board.pairs_seen,
             board.dones_seen);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out waiting for pair transfers.");
    $display("status: fail");
    $finish;
  end
endmodule
